// File: design/lgra_pkg.sv
// Shared types, constants and a helper function for the lattice gas block.
package lgra_pkg;

	localparam int X_BITS      = 8;
	localparam int Y_BITS      = 8;
	localparam int GRID_WIDTH  = 1 << X_BITS;
	localparam int GRID_HEIGHT = 1 << Y_BITS;
	localparam int CELL_BITS   = X_BITS + Y_BITS;
	localparam int DIRS        = 4;
	localparam int BANKS       = 2;
	localparam int THR_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [CELL_BITS-1:0] cell_addr_t;
	typedef logic [DIRS-1:0]      cell_bits_t;
	typedef logic [THR_BITS-1:0]  thr_t;
	typedef logic [1:0]           shift_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_KEEP     = 2'd0,
		REG_TURN_ONE = 2'd1,
		REG_REVERSE  = 2'd2,
		REG_UNUSED   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_DRAIN
	} state_t;

	typedef cell_addr_t plane_addr_t [DIRS];

	localparam cell_addr_t CELL_LAST = '1;

	// Collision as a rotation: new bit i takes old bit (i - shift) mod 4.
	function automatic shift_t collide_shift(thr_t r, thr_t keep, thr_t turn, thr_t rev);
		shift_t s;
		if (r < keep) begin
			s = 2'd0;
		end else if (r < turn) begin
			s = 2'd1;
		end else if (r < rev) begin
			s = 2'd2;
		end else begin
			s = 2'd3;
		end
		return s;
	endfunction

endpackage

// File: design/lgra_ram.sv
// Single-bit synchronous RAM, one write port and one registered read port.
module lgra_ram (
	input  logic                   clk,
	input  logic                   we,
	input  lgra_pkg::cell_addr_t   waddr,
	input  logic                   wdata,
	input  lgra_pkg::cell_addr_t   raddr,
	output logic                   rdata
);

	logic mem [1 << lgra_pkg::CELL_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/lgra_sweep.sv
// Neighbor address generation for one target cell of a lattice step.
module lgra_sweep (
	input  lgra_pkg::cell_addr_t  tgt,
	input  lgra_pkg::shift_t      shift,
	output lgra_pkg::plane_addr_t plane_raddr
);

	logic [lgra_pkg::X_BITS-1:0] xs;
	logic [lgra_pkg::Y_BITS-1:0] ys;
	lgra_pkg::plane_addr_t       nb;

	assign xs = tgt[lgra_pkg::X_BITS-1:0];
	assign ys = tgt[lgra_pkg::CELL_BITS-1:lgra_pkg::X_BITS];

	// New bit i of the target comes from the cell it moved out of.
	always_comb begin
		nb[0] = {ys, lgra_pkg::X_BITS'(xs - 1'b1)};
		nb[1] = {lgra_pkg::Y_BITS'(ys - 1'b1), xs};
		nb[2] = {ys, lgra_pkg::X_BITS'(xs + 1'b1)};
		nb[3] = {lgra_pkg::Y_BITS'(ys + 1'b1), xs};
	end

	// Plane p feeds new bit (p + shift) mod 4, so each plane sees one address.
	always_comb begin
		for (int p = 0; p < lgra_pkg::DIRS; p++) begin
			plane_raddr[p] = nb[2'(p) + shift];
		end
	end

endmodule

// File: design/lattice_gas_rotate_advect.sv
// Top level of the four-direction lattice gas with rotate and advect step.
//
// channel  direction  handshake              payload
// in       to block   in_valid / in_ready    command, cell_x, cell_y, cell_bits_in,
//                                            random_fraction
// out      from block out_valid / out_ready  cell_bits_out, done_kind
// cfg      to block   cfg_write_en           cfg_index, cfg_write_data
//
// A step sweeps all 65536 cells at one cell per cycle; the sweep rate is set by the
// single read port of each bit plane of the lattice memory.
// After reset the block clears the bank that the first step reads, one cell a cycle,
// and takes no word until that is done; configuration writes are taken throughout.
// One word is worked at a time; the next is taken as the result word leaves.
module lattice_gas_rotate_advect (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [lgra_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [lgra_pkg::THR_BITS-1:0]         cfg_write_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            command,
	input  logic [lgra_pkg::X_BITS-1:0]           cell_x,
	input  logic [lgra_pkg::Y_BITS-1:0]           cell_y,
	input  logic [lgra_pkg::DIRS-1:0]             cell_bits_in,
	input  logic [lgra_pkg::THR_BITS-1:0]         random_fraction,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [lgra_pkg::DIRS-1:0]             cell_bits_out,
	output logic [1:0]                            done_kind
);

	lgra_pkg::state_t     state_q, state_nxt;
	lgra_pkg::cell_addr_t cnt_q;
	lgra_pkg::shift_t     shift_q;
	logic                 cur_bank_q;
	lgra_pkg::thr_t       keep_thr_q, turn_thr_q, rev_thr_q;

	// step pipeline: stage 1 holds the target whose neighbor bits are in the RAMs
	logic                 valid_s1;
	lgra_pkg::cell_addr_t tgt_s1;

	logic                 out_valid_q;
	lgra_pkg::cell_bits_t out_bits_q;
	logic [1:0]           out_kind_q;

	logic                 accept;
	lgra_pkg::cmd_t       cmd;
	lgra_pkg::cell_addr_t cmd_addr;
	lgra_pkg::plane_addr_t step_raddr;
	lgra_pkg::cell_bits_t  src_bits;
	lgra_pkg::cell_bits_t  new_bits;

	logic                 ram_we    [lgra_pkg::BANKS][lgra_pkg::DIRS];
	lgra_pkg::cell_addr_t ram_waddr [lgra_pkg::BANKS][lgra_pkg::DIRS];
	logic                 ram_wdata [lgra_pkg::BANKS][lgra_pkg::DIRS];
	lgra_pkg::cell_addr_t ram_raddr [lgra_pkg::BANKS][lgra_pkg::DIRS];
	logic                 ram_rdata [lgra_pkg::BANKS][lgra_pkg::DIRS];

	assign cmd      = lgra_pkg::cmd_t'(command);
	assign cmd_addr = {cell_y, cell_x};
	assign accept   = in_valid && in_ready;

	assign out_valid     = out_valid_q;
	assign cell_bits_out = out_bits_q;
	assign done_kind     = out_kind_q;

	// Two banks of four bit planes; a step reads one bank and writes the other.
	for (genvar b = 0; b < lgra_pkg::BANKS; b++) begin : g_bank
		for (genvar p = 0; p < lgra_pkg::DIRS; p++) begin : g_plane
			lgra_ram u_ram (
				.clk   (clk),
				.we    (ram_we[b][p]),
				.waddr (ram_waddr[b][p]),
				.wdata (ram_wdata[b][p]),
				.raddr (ram_raddr[b][p]),
				.rdata (ram_rdata[b][p])
			);
		end
	end

	lgra_sweep u_sweep (
		.tgt         (cnt_q),
		.shift       (shift_q),
		.plane_raddr (step_raddr)
	);

	// Gather the read data of the current bank and rotate it into place.
	always_comb begin
		for (int p = 0; p < lgra_pkg::DIRS; p++) begin
			src_bits[p] = ram_rdata[cur_bank_q][p];
		end
		new_bits = (src_bits << shift_q) | (src_bits >> (3'd4 - {1'b0, shift_q}));
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lgra_pkg::ST_CLEAR: begin
				if (cnt_q == lgra_pkg::CELL_LAST) state_nxt = lgra_pkg::ST_IDLE;
			end
			lgra_pkg::ST_IDLE: begin
				if (accept && cmd == lgra_pkg::CMD_READ) begin
					state_nxt = lgra_pkg::ST_READ;
				end else if (accept && cmd == lgra_pkg::CMD_STEP) begin
					state_nxt = lgra_pkg::ST_STEP;
				end
			end
			lgra_pkg::ST_READ:  state_nxt = lgra_pkg::ST_IDLE;
			lgra_pkg::ST_STEP: begin
				if (cnt_q == lgra_pkg::CELL_LAST) state_nxt = lgra_pkg::ST_DRAIN;
			end
			lgra_pkg::ST_DRAIN: state_nxt = lgra_pkg::ST_IDLE;
			default:            state_nxt = lgra_pkg::ST_IDLE;
		endcase
	end

	// Handshake and memory control.
	always_comb begin
		in_ready = (state_q == lgra_pkg::ST_IDLE) && (!out_valid_q || out_ready);
		for (int b = 0; b < lgra_pkg::BANKS; b++) begin
			for (int p = 0; p < lgra_pkg::DIRS; p++) begin
				ram_we[b][p]    = 1'b0;
				ram_waddr[b][p] = tgt_s1;
				ram_wdata[b][p] = new_bits[p];
				ram_raddr[b][p] = cmd_addr;
				case (state_q)
					lgra_pkg::ST_CLEAR: begin
						// zero the bank that the first step reads
						if (b == 0) begin
							ram_we[b][p]    = 1'b1;
							ram_waddr[b][p] = cnt_q;
							ram_wdata[b][p] = 1'b0;
						end
					end
					lgra_pkg::ST_IDLE: begin
						if (1'(b) == cur_bank_q && accept && cmd == lgra_pkg::CMD_WRITE) begin
							ram_we[b][p]    = 1'b1;
							ram_waddr[b][p] = cmd_addr;
							ram_wdata[b][p] = cell_bits_in[p];
						end
					end
					lgra_pkg::ST_STEP: begin
						if (1'(b) == cur_bank_q) ram_raddr[b][p] = step_raddr[p];
					end
					default: begin
					end
				endcase
				// write back the advected cell into the other bank
				if (valid_s1 && 1'(b) != cur_bank_q) ram_we[b][p] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lgra_pkg::ST_CLEAR;
			cnt_q       <= '0;
			shift_q     <= '0;
			cur_bank_q  <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			keep_thr_q  <= 16'd16384;
			turn_thr_q  <= 16'd32768;
			rev_thr_q   <= 16'd49152;
		end else begin
			state_q  <= state_nxt;
			valid_s1 <= (state_q == lgra_pkg::ST_STEP);

			if (cfg_write_en) begin
				case (lgra_pkg::reg_idx_t'(cfg_index))
					lgra_pkg::REG_KEEP:     keep_thr_q <= cfg_write_data;
					lgra_pkg::REG_TURN_ONE: turn_thr_q <= cfg_write_data;
					lgra_pkg::REG_REVERSE:  rev_thr_q  <= cfg_write_data;
					default: begin
					end
				endcase
			end

			// advance the sweep counter; restart it whenever a word is taken
			if (state_q == lgra_pkg::ST_CLEAR || state_q == lgra_pkg::ST_STEP) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (accept) begin
				cnt_q <= '0;
			end

			if (accept && cmd == lgra_pkg::CMD_STEP) begin
				shift_q <= lgra_pkg::collide_shift(random_fraction, keep_thr_q,
					turn_thr_q, rev_thr_q);
			end

			if (state_q == lgra_pkg::ST_DRAIN) cur_bank_q <= !cur_bank_q;

			// result register: load on completion, drop once taken
			if (accept && (cmd == lgra_pkg::CMD_WRITE || cmd == lgra_pkg::CMD_NONE)) begin
				out_valid_q <= 1'b1;
			end else if (state_q == lgra_pkg::ST_READ || state_q == lgra_pkg::ST_DRAIN) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tgt_s1 <= cnt_q;
		if (accept) begin
			out_bits_q <= '0;
			out_kind_q <= command;
		end else if (state_q == lgra_pkg::ST_READ) begin
			out_bits_q <= src_bits;
		end
	end

endmodule
